// File: hw/rtl/tdt_pkg.sv
// Shared types and constants for the deadline timer table.
// Used by every module of the block but tdt_alu, and by its checker; depends on nothing.
package tdt_pkg;

  localparam int unsigned DefaultSlots = 16;
  localparam logic [31:0] DefaultWindowMs = 32'd3600000;

  typedef enum logic [2:0] {
    CmdAdd     = 3'd0,
    CmdCancel  = 3'd1,
    CmdRefresh = 3'd2,
    CmdReset   = 3'd3,
    CmdExpire  = 3'd4,
    CmdQuery   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNotFound = 2'd1,
    StFull     = 2'd2,
    StNone     = 2'd3
  } status_e;

  typedef struct packed {
    logic dl_we;
    logic iv_we;
  } wr_t;

endpackage

// File: hw/rtl/tdt_alu.sv
// Shared 64-bit adder and subtractor with an unsigned less-than flag.
// Depends on nothing; driven by the sequencer in tdt_seq.
module tdt_alu (
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic        sub_i,
  output logic [63:0] sum_o,
  output logic        lt_o
);

  logic [64:0] res;

  always_comb begin
    if (sub_i) begin
      res = {1'b0, a_i} - {1'b0, b_i};
    end else begin
      res = {1'b0, a_i} + {1'b0, b_i};
    end
  end

  assign sum_o = res[63:0];
  assign lt_o  = sub_i & res[64];

endmodule

// File: hw/rtl/tdt_store.sv
// Deadline and interval memories of the timer slots, one write and one read port.
// Depends on tdt_pkg for the write control struct.
module tdt_store #(
  parameter int unsigned Slots = tdt_pkg::DefaultSlots,
  localparam int unsigned IdxW = $clog2(Slots)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [IdxW-1:0] rd_addr_i,
  input  tdt_pkg::wr_t    wr_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  logic [63:0]     wr_dl_i,
  input  logic [63:0]     wr_iv_i,
  output logic [63:0]     rd_dl_o,
  output logic [63:0]     rd_iv_o
);
  import tdt_pkg::*;

  logic [63:0] dl_mem [Slots];
  logic [63:0] iv_mem [Slots];
  logic [Slots-1:0] iv_known_q;
  logic        iv_known_rd_q;
  logic [63:0] iv_raw_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.dl_we) begin
      dl_mem[wr_addr_i] <= wr_dl_i;
    end
    if (wr_i.iv_we) begin
      iv_mem[wr_addr_i] <= wr_iv_i;
    end
    rd_dl_o  <= dl_mem[rd_addr_i];
    iv_raw_q <= iv_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_known_q    <= '0;
      iv_known_rd_q <= 1'b0;
    end else begin
      if (wr_i.iv_we) begin
        iv_known_q[wr_addr_i] <= 1'b1;
      end
      iv_known_rd_q <= iv_known_q[rd_addr_i];
    end
  end

  assign rd_iv_o = iv_known_rd_q ? iv_raw_q : '0;

endmodule

// File: hw/rtl/tdt_seq.sv
// Command sequencer of the timer table: slot scans, active marks and results.
// Depends on tdt_pkg, the shared unit tdt_alu and the memories in tdt_store.
module tdt_seq #(
  parameter int unsigned Slots = tdt_pkg::DefaultSlots,
  localparam int unsigned IdxW = $clog2(Slots)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [2:0]       command_i,
  input  logic [3:0]       slot_i,
  input  logic [63:0]      now_ms_i,
  input  logic [63:0]      period_ms_i,
  input  logic             repeat_req_i,
  input  logic             from_now_i,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [31:0]      cfg_data_i,
  output logic [IdxW-1:0]  rd_addr_o,
  output tdt_pkg::wr_t     wr_o,
  output logic [IdxW-1:0]  wr_addr_o,
  output logic [63:0]      wr_dl_o,
  output logic [63:0]      wr_iv_o,
  input  logic [63:0]      rd_dl_i,
  input  logic [63:0]      rd_iv_i,
  output logic [63:0]      alu_a_o,
  output logic [63:0]      alu_b_o,
  output logic             alu_sub_o,
  input  logic [63:0]      alu_sum_i,
  input  logic             alu_lt_i,
  output logic             result_valid_o,
  output logic [3:0]       slot_id_o,
  output logic [1:0]       status_o,
  output logic             earliest_o,
  output logic [63:0]      delay_ms_o,
  output logic             any_active_o,
  output logic             last_o
);
  import tdt_pkg::*;

  localparam int unsigned CntW = $clog2(Slots + 1);

  typedef enum logic [3:0] {
    SIdle, SDisp, SScan, SAddWr, SFront, SRd, SChk, SNewDl,
    SRoll1, SRoll2, SFired, SExpRd, SExpUpd, SQres, SResp
  } state_e;

  state_e          state_q, scan_next_q;
  cmd_e            cmd_q;
  logic [IdxW-1:0] tgt_q, pidx_q, best_idx_q, free_idx_q;
  logic            inrange_q, rep_req_q, fnow_q;
  logic [63:0]     now_q, period_q, prev_q, best_dl_q, tmp_q, r_delay_q;
  logic [31:0]     window_q;
  logic [Slots-1:0] active_q, rep_q, fire_q, mask_q;
  logic [CntW-1:0] cnt_q;
  logic            pv_q, best_v_q, free_v_q, roll_q, fire_mode_q, final_any_q;
  logic [3:0]      r_slot_q;
  status_e         r_status_q;
  logic            r_front_q, r_last_q;
  logic [IdxW-1:0] cnt_idx;
  logic            cnt_end;

  assign busy        = (state_q != SIdle);
  assign cfg_ready_o = 1'b1;
  assign cnt_idx     = cnt_q[IdxW-1:0];
  assign cnt_end     = (cnt_q == CntW'(Slots));

  always_comb begin
    case (state_q)
      SScan:   rd_addr_o = cnt_idx;
      SExpRd:  rd_addr_o = best_idx_q;
      default: rd_addr_o = tgt_q;
    endcase
  end

  always_comb begin
    alu_a_o   = '0;
    alu_b_o   = '0;
    alu_sub_o = 1'b0;
    wr_o      = '0;
    wr_addr_o = tgt_q;
    wr_dl_o   = alu_sum_i;
    wr_iv_o   = period_q;
    case (state_q)
      SScan: begin
        alu_sub_o = 1'b1;
        if (fire_mode_q) begin
          alu_a_o = now_q;
          alu_b_o = rd_dl_i;
        end else begin
          alu_a_o = rd_dl_i;
          alu_b_o = best_dl_q;
        end
      end
      SRoll1: begin
        alu_a_o   = prev_q;
        alu_b_o   = now_q;
        alu_sub_o = 1'b1;
      end
      SRoll2: begin
        alu_a_o   = {32'b0, window_q};
        alu_b_o   = tmp_q;
        alu_sub_o = 1'b1;
      end
      SAddWr: begin
        alu_a_o    = now_q;
        alu_b_o    = period_q;
        wr_o.dl_we = free_v_q;
        wr_o.iv_we = free_v_q;
        wr_addr_o  = free_idx_q;
      end
      SFront: begin
        alu_a_o   = best_dl_q;
        alu_b_o   = tmp_q;
        alu_sub_o = 1'b1;
      end
      SChk: begin
        if (cmd_q == CmdRefresh) begin
          alu_a_o    = now_q;
          alu_b_o    = rd_iv_i;
          wr_o.dl_we = 1'b1;
        end else begin
          alu_a_o   = rd_dl_i;
          alu_b_o   = rd_iv_i;
          alu_sub_o = 1'b1;
        end
      end
      SNewDl: begin
        alu_a_o    = tmp_q;
        alu_b_o    = period_q;
        wr_o.dl_we = 1'b1;
        wr_o.iv_we = 1'b1;
      end
      SExpUpd: begin
        alu_a_o    = now_q;
        alu_b_o    = rd_iv_i;
        wr_o.dl_we = rep_q[best_idx_q];
        wr_addr_o  = best_idx_q;
      end
      SQres: begin
        alu_a_o   = best_dl_q;
        alu_b_o   = now_q;
        alu_sub_o = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= SIdle;
      scan_next_q    <= SIdle;
      cmd_q          <= CmdAdd;
      tgt_q          <= '0;
      pidx_q         <= '0;
      best_idx_q     <= '0;
      free_idx_q     <= '0;
      inrange_q      <= 1'b0;
      rep_req_q      <= 1'b0;
      fnow_q         <= 1'b0;
      now_q          <= '0;
      period_q       <= '0;
      prev_q         <= '0;
      best_dl_q      <= '0;
      tmp_q          <= '0;
      r_delay_q      <= '0;
      window_q       <= DefaultWindowMs;
      active_q       <= '0;
      rep_q          <= '0;
      fire_q         <= '0;
      mask_q         <= '0;
      cnt_q          <= '0;
      pv_q           <= 1'b0;
      best_v_q       <= 1'b0;
      free_v_q       <= 1'b0;
      roll_q         <= 1'b0;
      fire_mode_q    <= 1'b0;
      final_any_q    <= 1'b0;
      r_slot_q       <= '0;
      r_status_q     <= StOk;
      r_front_q      <= 1'b0;
      r_last_q       <= 1'b1;
      result_valid_o <= 1'b0;
      slot_id_o      <= '0;
      status_o       <= '0;
      earliest_o     <= 1'b0;
      delay_ms_o     <= '0;
      any_active_o   <= 1'b0;
      last_o         <= 1'b0;
    end else begin
      result_valid_o <= (state_q == SResp);
      if (cfg_valid_i) begin
        window_q <= cfg_data_i;
      end
      case (state_q)
        SIdle: begin
          if (start) begin
            cmd_q      <= cmd_e'(command_i);
            tgt_q      <= IdxW'(slot_i);
            inrange_q  <= (32'(slot_i) < 32'(Slots));
            now_q      <= now_ms_i;
            period_q   <= period_ms_i;
            rep_req_q  <= repeat_req_i;
            fnow_q     <= from_now_i;
            r_slot_q   <= '0;
            r_status_q <= StOk;
            r_front_q  <= 1'b0;
            r_delay_q  <= '0;
            r_last_q   <= 1'b1;
            state_q    <= SDisp;
          end
        end
        SDisp: begin
          case (cmd_q)
            CmdAdd, CmdQuery: begin
              cnt_q       <= '0;
              pv_q        <= 1'b0;
              best_v_q    <= 1'b0;
              free_v_q    <= 1'b0;
              fire_mode_q <= 1'b0;
              mask_q      <= active_q;
              scan_next_q <= (cmd_q == CmdAdd) ? SAddWr : SQres;
              state_q     <= SScan;
            end
            CmdCancel, CmdRefresh: begin
              if (!inrange_q || !active_q[tgt_q]) begin
                r_status_q <= StNotFound;
                state_q    <= SResp;
              end else if (cmd_q == CmdCancel) begin
                active_q[tgt_q] <= 1'b0;
                state_q         <= SResp;
              end else begin
                state_q <= SRd;
              end
            end
            CmdReset: begin
              if (!inrange_q) begin
                r_status_q <= StNotFound;
                state_q    <= SResp;
              end else begin
                state_q <= SRd;
              end
            end
            CmdExpire: begin
              if (active_q == '0) begin
                r_status_q  <= StNone;
                final_any_q <= 1'b0;
                state_q     <= SResp;
              end else begin
                state_q <= SRoll1;
              end
            end
            default: begin
              r_status_q <= StNotFound;
              state_q    <= SResp;
            end
          endcase
        end
        SScan: begin
          if (!cnt_end) begin
            pv_q   <= 1'b1;
            pidx_q <= cnt_idx;
            cnt_q  <= cnt_q + CntW'(1);
            if (!free_v_q && !active_q[cnt_idx]) begin
              free_v_q   <= 1'b1;
              free_idx_q <= cnt_idx;
            end
          end else begin
            pv_q <= 1'b0;
          end
          if (pv_q) begin
            if (fire_mode_q) begin
              fire_q[pidx_q] <= active_q[pidx_q] && (roll_q || !alu_lt_i);
            end else if (mask_q[pidx_q] && (!best_v_q || alu_lt_i)) begin
              best_v_q   <= 1'b1;
              best_idx_q <= pidx_q;
              best_dl_q  <= rd_dl_i;
            end
          end
          if (cnt_end && !pv_q) begin
            state_q <= scan_next_q;
          end
        end
        SAddWr: begin
          if (!free_v_q) begin
            r_status_q <= StFull;
            state_q    <= SResp;
          end else begin
            active_q[free_idx_q] <= 1'b1;
            rep_q[free_idx_q]    <= rep_req_q;
            tmp_q                <= alu_sum_i;
            tgt_q                <= free_idx_q;
            r_slot_q             <= 4'(free_idx_q);
            state_q              <= SFront;
          end
        end
        SFront: begin
          r_front_q <= !best_v_q ||
                       !(alu_lt_i || ((alu_sum_i == '0) && (best_idx_q < tgt_q)));
          state_q   <= SResp;
        end
        SRd: begin
          state_q <= SChk;
        end
        SChk: begin
          if (cmd_q == CmdRefresh) begin
            state_q <= SResp;
          end else if ((rd_iv_i == period_q) && !fnow_q) begin
            state_q <= SResp;
          end else if (!active_q[tgt_q]) begin
            r_status_q <= StNotFound;
            state_q    <= SResp;
          end else begin
            tmp_q   <= fnow_q ? now_q : alu_sum_i;
            state_q <= SNewDl;
          end
        end
        SNewDl: begin
          tmp_q       <= alu_sum_i;
          cnt_q       <= '0;
          pv_q        <= 1'b0;
          best_v_q    <= 1'b0;
          free_v_q    <= 1'b0;
          fire_mode_q <= 1'b0;
          mask_q      <= active_q & ~(Slots'(1) << tgt_q);
          scan_next_q <= SFront;
          state_q     <= SScan;
        end
        SRoll1: begin
          tmp_q   <= alu_sum_i;
          roll_q  <= !alu_lt_i && (alu_sum_i != '0);
          state_q <= SRoll2;
        end
        SRoll2: begin
          roll_q      <= roll_q && alu_lt_i;
          prev_q      <= now_q;
          fire_q      <= '0;
          cnt_q       <= '0;
          pv_q        <= 1'b0;
          free_v_q    <= 1'b0;
          fire_mode_q <= 1'b1;
          scan_next_q <= SFired;
          state_q     <= SScan;
        end
        SFired: begin
          if (fire_q == '0) begin
            r_status_q  <= StNone;
            final_any_q <= |active_q;
            state_q     <= SResp;
          end else begin
            final_any_q <= |(active_q & ~(fire_q & ~rep_q));
            cnt_q       <= '0;
            pv_q        <= 1'b0;
            best_v_q    <= 1'b0;
            free_v_q    <= 1'b0;
            fire_mode_q <= 1'b0;
            mask_q      <= fire_q;
            scan_next_q <= SExpRd;
            state_q     <= SScan;
          end
        end
        SExpRd: begin
          state_q <= SExpUpd;
        end
        SExpUpd: begin
          if (!rep_q[best_idx_q]) begin
            active_q[best_idx_q] <= 1'b0;
          end
          fire_q[best_idx_q] <= 1'b0;
          r_slot_q           <= 4'(best_idx_q);
          r_last_q           <= ((fire_q & ~(Slots'(1) << best_idx_q)) == '0);
          state_q            <= SResp;
        end
        SQres: begin
          if (!best_v_q) begin
            r_delay_q <= '1;
          end else if (alu_lt_i || (alu_sum_i == '0)) begin
            r_delay_q <= '0;
          end else begin
            r_delay_q <= alu_sum_i;
          end
          state_q <= SResp;
        end
        SResp: begin
          slot_id_o      <= r_slot_q;
          status_o       <= r_status_q;
          earliest_o     <= r_front_q;
          delay_ms_o     <= r_delay_q;
          last_o         <= r_last_q;
          any_active_o   <= (cmd_q == CmdExpire) ? final_any_q : |active_q;
          if (!r_last_q) begin
            cnt_q       <= '0;
            pv_q        <= 1'b0;
            best_v_q    <= 1'b0;
            free_v_q    <= 1'b0;
            fire_mode_q <= 1'b0;
            mask_q      <= fire_q;
            scan_next_q <= SExpRd;
            state_q     <= SScan;
          end else begin
            state_q <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/deadline_timer_table_top.sv
// Top level of the deadline timer table: sequencer, shared adder and slot memories.
// Depends on tdt_pkg, tdt_alu, tdt_store and tdt_seq.
//
// A command is taken when start is high and busy is low; busy then stays high until its
// last result has been issued. Each result appears for a single cycle with result_valid_o
// high and must be captured then, as the block cannot be held off. Cancel, refresh,
// unknown commands, expire on an empty table and resets that leave the deadline alone
// answer without a scan of the slots; query, add and a reset that moves the deadline
// scan once, and expire scans once when nothing is due, otherwise twice to its first
// result and once more to each further one. Every scan walks the slots through the
// single read port of the deadline memory, one slot per cycle, and all deadline
// arithmetic shares the one 64-bit adder.
module deadline_timer_table_top #(
  parameter int unsigned Slots = tdt_pkg::DefaultSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command_i,
  input  logic [3:0]  slot_i,
  input  logic [63:0] now_ms_i,
  input  logic [63:0] period_ms_i,
  input  logic        repeat_req_i,
  input  logic        from_now_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  output logic        result_valid_o,
  output logic [3:0]  slot_id_o,
  output logic [1:0]  status_o,
  output logic        earliest_o,
  output logic [63:0] delay_ms_o,
  output logic        any_active_o,
  output logic        last_o
);
  import tdt_pkg::*;

  localparam int unsigned IdxW = $clog2(Slots);

  logic [IdxW-1:0] rd_addr, wr_addr;
  wr_t             wr;
  logic [63:0]     wr_dl, wr_iv, rd_dl, rd_iv;
  logic [63:0]     alu_a, alu_b, alu_sum;
  logic            alu_sub, alu_lt;

  tdt_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .sum_o (alu_sum),
    .lt_o  (alu_lt)
  );

  tdt_store #(.Slots(Slots)) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .wr_i      (wr),
    .wr_addr_i (wr_addr),
    .wr_dl_i   (wr_dl),
    .wr_iv_i   (wr_iv),
    .rd_dl_o   (rd_dl),
    .rd_iv_o   (rd_iv)
  );

  tdt_seq #(.Slots(Slots)) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .slot_i         (slot_i),
    .now_ms_i       (now_ms_i),
    .period_ms_i    (period_ms_i),
    .repeat_req_i   (repeat_req_i),
    .from_now_i     (from_now_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .rd_addr_o      (rd_addr),
    .wr_o           (wr),
    .wr_addr_o      (wr_addr),
    .wr_dl_o        (wr_dl),
    .wr_iv_o        (wr_iv),
    .rd_dl_i        (rd_dl),
    .rd_iv_i        (rd_iv),
    .alu_a_o        (alu_a),
    .alu_b_o        (alu_b),
    .alu_sub_o      (alu_sub),
    .alu_sum_i      (alu_sum),
    .alu_lt_i       (alu_lt),
    .result_valid_o (result_valid_o),
    .slot_id_o      (slot_id_o),
    .status_o       (status_o),
    .earliest_o     (earliest_o),
    .delay_ms_o     (delay_ms_o),
    .any_active_o   (any_active_o),
    .last_o         (last_o)
  );

endmodule

// File: hw/rtl/tdt_checker.sv
// Port-level checks of the deadline timer table, bound to its top level.
// Depends on tdt_pkg for the status codes.
module tdt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        result_valid_o,
  input logic [3:0]  slot_id_o,
  input logic [1:0]  status_o,
  input logic        earliest_o,
  input logic [63:0] delay_ms_o,
  input logic        last_o
);
  import tdt_pkg::*;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("command taken but busy did not rise");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result issued without a command in progress");

  a_error_is_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o != StOk)) |-> (last_o && (slot_id_o == '0)))
    else $error("error result is not a single final result");

  a_delay_only_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (delay_ms_o != '0)) |->
      ((status_o == StOk) && !earliest_o && (slot_id_o == '0) && last_o))
    else $error("delay reported on a result that is not a query");

endmodule

bind deadline_timer_table_top tdt_checker u_tdt_checker (.*);
